### rtl/u8d_pkg.sv
// u8d_pkg: shared types, status codes and constants for the utf-8 byte stream decoder
// no dependencies; imported by the interfaces and all decoder modules

package u8d_pkg;

  // longest character accepted, in bytes (range 2 to 4)
  localparam int MAX_BYTES = 4;

  localparam int BYTE_W   = 8;
  localparam int CP_W     = 21;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 2;

  // continuation bytes allowed after a lead
  localparam logic [COUNT_W-1:0] CONT_CAP = COUNT_W'(MAX_BYTES - 1);
  // lead bit that, when set with the whole run above it, marks an over-long lead
  localparam int TOO_LONG_BIT = 7 - MAX_BYTES;

  // bit positions of the lead and sub-lead marks in a byte
  localparam int TOP_BIT = 7;
  localparam int SUB_BIT = 6;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STRAY_CONT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CONT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ_END   = 3'd5;

  typedef struct packed {
    logic [CP_W-1:0]    accumulator;
    logic [COUNT_W-1:0] bytes_left;
    logic [COUNT_W-1:0] bytes_taken;
    logic               too_long_lead;
  } u8d_state_t;

  typedef struct packed {
    logic [CP_W-1:0]     code_point;
    logic [STATUS_W-1:0] status;
  } u8d_result_t;

  // code point mask for a character with the given number of continuation bytes
  function automatic logic [CP_W-1:0] cp_mask(input logic [COUNT_W-1:0] taken);
    logic [CP_W-1:0] m;
    unique case (taken)
      2'd0: m = CP_W'(21'h00003F);
      2'd1: m = CP_W'(21'h0007FF);
      2'd2: m = CP_W'(21'h00FFFF);
      2'd3: m = CP_W'(21'h1FFFFF);
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

### rtl/u8d_byte_if.sv
// u8d_byte_if: valid/ready channel carrying one stream byte or the end mark per beat
// depends on u8d_pkg

interface u8d_byte_if
  import u8d_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              end_mark;

  modport source (output valid, output byte_value, output end_mark, input ready);
  modport sink   (input valid, input byte_value, input end_mark, output ready);
endinterface

### rtl/u8d_char_if.sv
// u8d_char_if: valid/ready channel carrying one decoded code point and status per beat
// depends on u8d_pkg

interface u8d_char_if
  import u8d_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CP_W-1:0]     code_point;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output code_point, output status, input ready);
  modport sink   (input valid, input code_point, input status, output ready);
endinterface

### rtl/utf8_byte_stream_decoder_core.sv
// utf8_byte_stream_decoder_core: top level of the utf-8 byte stream decoder
// depends on u8d_pkg, u8d_byte_if, u8d_char_if, u8d_decode and u8d_out_buf

// Decodes a utf-8 byte stream, one byte per beat on bytes, into code points on
// chars. An ascii byte yields its code point; a lead byte opens a character and
// yields nothing; each continuation byte adds six bits and the last one yields
// the code point, masked to 5*k+6 bits for k continuation bytes. A beat with
// end_mark set carries no byte and yields status truncated inside a character,
// or read-at-end when idle. Errors (stray continuation, bad continuation, a
// lead announcing more than MAX_BYTES bytes, flagged on its last byte) give
// code point zero and return the decoder to idle; overlong forms pass through.
// Throughput is one byte per cycle: the decoder state is updated once per byte, and
// a result appears on chars the cycle after its byte is taken when the result
// register is free, otherwise it waits in the skid entry until the held result is
// taken. A result register plus one skid entry keep bytes flowing while one result
// waits; bytes stall only once both are full.

module utf8_byte_stream_decoder_core
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  u8d_byte_if.sink    bytes,
  u8d_char_if.source  chars
);

  logic        take;       // byte beat accepted
  logic        res_valid;  // accepted beat yields a result
  logic        space;      // room in the output buffer
  logic        skid_valid;
  u8d_result_t res;
  u8d_result_t out_data;
  u8d_state_t  state;

  assign bytes.ready = space;
  assign take        = bytes.valid && space;

  // decoder state and per-byte logic
  u8d_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .byte_value (bytes.byte_value),
    .end_mark   (bytes.end_mark),
    .res_valid  (res_valid),
    .res        (res),
    .state      (state)
  );

  // result register and skid entry
  u8d_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (take && res_valid),
    .push_data  (res),
    .space      (space),
    .out_valid  (chars.valid),
    .out_ready  (chars.ready),
    .out_data   (out_data),
    .skid_valid (skid_valid)
  );

  assign chars.code_point = out_data.code_point;
  assign chars.status     = out_data.status;

`ifndef NO_ASSERTIONS
  // the skid entry is only ever filled behind a held result
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> chars.valid)
    else $error("skid entry valid without a result on chars");

  // error results never carry a code point
  a_err_zero_cp : assert property (@(posedge clk) disable iff (rst)
    (chars.valid && (chars.status != ST_OK)) |-> (chars.code_point == '0))
    else $error("error result with non-zero code point");

  // idle decoder holds no partial character
  a_idle_clean : assert property (@(posedge clk) disable iff (rst)
    (state.bytes_left == '0) |-> ((state.bytes_taken == '0) && !state.too_long_lead))
    else $error("idle decoder with stale character state");

  // an end beat always leaves the decoder idle
  a_end_idles : assert property (@(posedge clk) disable iff (rst)
    (take && bytes.end_mark) |=> (state.bytes_left == '0))
    else $error("decoder not idle after end of stream");

  // every accepted end beat produces a result on chars
  a_end_result : assert property (@(posedge clk) disable iff (rst)
    (take && bytes.end_mark) |=> chars.valid)
    else $error("end beat produced no result");
`endif

endmodule

### rtl/u8d_decode.sv
// u8d_decode: decoder state register and the single-pass next-state / result logic
// depends on u8d_pkg

module u8d_decode
  import u8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [BYTE_W-1:0] byte_value,
  input  logic              end_mark,
  output logic              res_valid,
  output u8d_result_t       res,
  output u8d_state_t        state
);

  u8d_state_t         state_next;
  logic [COUNT_W-1:0] run_len;
  logic               run_on;
  logic [COUNT_W-1:0] left_dec;
  logic [COUNT_W-1:0] taken_inc;
  logic [CP_W-1:0]    acc_shift;
  logic               is_cont;

  assign is_cont   = (byte_value[TOP_BIT] == 1'b1) && (byte_value[SUB_BIT] == 1'b0);
  assign left_dec  = state.bytes_left - COUNT_W'(1);
  assign taken_inc = state.bytes_taken + COUNT_W'(1);
  assign acc_shift = {state.accumulator[CP_W-7:0], byte_value[5:0]};

  // length of the run of set bits below the lead mark, capped
  always_comb begin
    run_len = '0;
    run_on  = 1'b1;
    for (int i = 0; i < MAX_BYTES - 1; i++) begin
      if (run_on && byte_value[SUB_BIT - i]) begin
        run_len = run_len + COUNT_W'(1);
      end else begin
        run_on = 1'b0;
      end
    end
  end

  always_comb begin
    state_next     = state;
    res_valid      = 1'b0;
    res.code_point = '0;
    res.status     = ST_OK;
    if (end_mark) begin
      res_valid = 1'b1;
      if (state.bytes_left != '0) begin
        res.status = ST_TRUNCATED;
        state_next = '0;
      end else begin
        res.status = ST_READ_END;
      end
    end else if (state.bytes_left == '0) begin
      if (!byte_value[TOP_BIT]) begin
        res_valid      = 1'b1;
        res.code_point = CP_W'(byte_value);
      end else if (!byte_value[SUB_BIT]) begin
        res_valid  = 1'b1;
        res.status = ST_STRAY_CONT;
      end else begin
        state_next.accumulator   = CP_W'(byte_value);
        state_next.bytes_left    = run_len;
        state_next.bytes_taken   = '0;
        state_next.too_long_lead = (run_len == CONT_CAP) && byte_value[TOO_LONG_BIT];
      end
    end else if (!is_cont) begin
      res_valid  = 1'b1;
      res.status = ST_BAD_CONT;
      state_next = '0;
    end else if (left_dec == '0) begin
      // last continuation byte closes the character
      res_valid  = 1'b1;
      state_next = '0;
      if (state.too_long_lead) begin
        res.status = ST_TOO_LONG;
      end else begin
        res.code_point = acc_shift & cp_mask(taken_inc);
      end
    end else begin
      state_next.accumulator = acc_shift;
      state_next.bytes_left  = left_dec;
      state_next.bytes_taken = taken_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (take) begin
      state <= state_next;
    end
  end

endmodule

### rtl/u8d_out_buf.sv
// u8d_out_buf: result register with a skid entry, decoupling the decoder from the sink
// depends on u8d_pkg

module u8d_out_buf
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  u8d_result_t push_data,
  output logic        space,
  output logic        out_valid,
  input  logic        out_ready,
  output u8d_result_t out_data,
  output logic        skid_valid
);

  u8d_result_t skid_data;
  logic        pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule
